// ===== hdl/ptts_pkg.sv =====
`timescale 1ns / 1ps

package ptts_pkg;

	// Configuration register indexes (byte address bit 2 selects the register).
	localparam logic REG_PREEMPT  = 1'b0;
	localparam logic REG_TICK_LEN = 1'b1;

	// Reset values of the configuration registers.
	localparam logic       PREEMPT_RST  = 1'b1;
	localparam logic [9:0] TICK_LEN_RST = 10'd1;

	// Live configuration handed from the register block to the scheduler.
	typedef struct packed {
		logic       preemptive_mode;
		logic [9:0] tick_length_ms;
	} cfg_t;

endpackage

// ===== hdl/ptts_incmp.sv =====
`timescale 1ns / 1ps

module ptts_incmp (
	input  logic [15:0] cnt,
	input  logic [15:0] limit,
	output logic [15:0] cnt_inc,
	output logic        hit
);
	// Shared counter step: increment with 16-bit wrap, then compare to the limit.
	assign cnt_inc = cnt + 16'd1;
	assign hit     = (cnt_inc == limit);

endmodule

// ===== hdl/ptts_cfg.sv =====
`timescale 1ns / 1ps

module ptts_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ptts_pkg::cfg_t     cfg
);
	import ptts_pkg::*;

	logic       preempt_q;
	logic [9:0] tick_len_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes on the access phase of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q  <= PREEMPT_RST;
			tick_len_q <= TICK_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_PREEMPT:  preempt_q  <= pwdata[0];
				REG_TICK_LEN: tick_len_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (paddr[2])
			REG_PREEMPT:  prdata = {31'd0, preempt_q};
			REG_TICK_LEN: prdata = {22'd0, tick_len_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.preemptive_mode = preempt_q;
	assign cfg.tick_length_ms  = tick_len_q;

endmodule

// ===== hdl/periodic_task_tick_scheduler_top.sv =====
`timescale 1ns / 1ps

// Periodic task tick scheduler.
// A command is transferred when start is high and busy is low. command = 1 loads a
// task (task_period, task_budget, task_rank) into the next free table entry; command
// = 0 runs one scheduling tick. Every command returns exactly one result, shown for
// a single cycle while done is high; the receiver cannot stall it.
// A load does not occupy the sequencer: done rises the cycle after the transfer and busy
// stays low, so a new command may follow at once.
// A tick is worked by a sequencer that walks the table entries one per cycle: a pick
// pass over the loaded tasks (skipped while a task runs without preemption, and ended
// at the first ready task when preemption is off), a charge step for the running task
// and a period pass over the loaded tasks; the charge step and the period pass share a
// single increment-and-compare unit. busy is high while the tick is worked and falls
// in the cycle in which done rises.
// Configuration uses the APB port: preemptive_mode at address 0, tick_length_ms at address 4;
// the user must write them only while the block is idle; the block itself does not enforce it.
// Reset clears the task count, the running task, the clock and both registers to
// preemptive mode with a 1 ms tick.
module periodic_task_tick_scheduler_top #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [15:0] task_period,
	input  logic [15:0] task_budget,
	input  logic [7:0]  task_rank,
	// result channel
	output logic        done,
	output logic [3:0]  ran_task,
	output logic        idle_slot,
	output logic [15:0] deadline_miss_mask,
	output logic [31:0] slot_start_ms,
	output logic        load_accepted,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ptts_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PICK = 4'b0010,
		S_RUN  = 4'b0100,
		S_ADV  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		ST_READY = 2'd0,
		ST_EXEC  = 2'd1,
		ST_SUSP  = 2'd2
	} run_st_t;

	cfg_t cfg;

	// Task tables.
	logic [15:0] period_q   [MAX_TASKS];
	logic [15:0] budget_q   [MAX_TASKS];
	logic [7:0]  rank_q     [MAX_TASKS];
	run_st_t     run_st_q   [MAX_TASKS];
	logic [15:0] progress_q [MAX_TASKS];
	logic [15:0] work_q     [MAX_TASKS];

	// Scheduler state.
	state_t          state_q;
	logic [CW-1:0]   loaded_q;
	logic [CW-1:0]   idx_q;
	logic            task_busy_q;
	logic [IW-1:0]   run_idx_q;
	logic [7:0]      run_rank_q;
	logic [31:0]     time_q;

	// Result registers.
	logic                 done_q;
	logic [3:0]           ran_q;
	logic                 idle_q;
	logic [MAX_TASKS-1:0] miss_q;
	logic [31:0]          slot_start_q;
	logic                 accepted_q;

	logic          take;
	logic [IW-1:0] ent;
	logic [IW-1:0] unit_addr;
	logic [15:0]   unit_cnt;
	logic [15:0]   unit_limit;
	logic [15:0]   unit_inc;
	logic          unit_hit;

	ptts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = (state_q != S_IDLE);
	assign take = start & ~busy;
	assign ent  = idx_q[IW-1:0];

	// The shared unit charges the running task in S_RUN and steps periods in S_ADV.
	assign unit_addr = (state_q == S_RUN) ? run_idx_q : ent;
	always_comb begin
		if (state_q == S_RUN) begin
			unit_cnt   = work_q[unit_addr];
			unit_limit = budget_q[unit_addr];
		end else begin
			unit_cnt   = progress_q[unit_addr];
			unit_limit = period_q[unit_addr];
		end
	end

	ptts_incmp u_incmp (
		.cnt     (unit_cnt),
		.limit   (unit_limit),
		.cnt_inc (unit_inc),
		.hit     (unit_hit)
	);

	// Tables: loads append an entry, the sequencer updates the run states.
	always_ff @(posedge clk) begin
		if (take && command && (loaded_q < MAX_CNT)) begin
			period_q[loaded_q[IW-1:0]] <= task_period;
			budget_q[loaded_q[IW-1:0]] <= task_budget;
			rank_q[loaded_q[IW-1:0]]   <= task_rank;
			run_st_q[loaded_q[IW-1:0]] <= ST_READY;
		end else begin
			unique case (state_q)
				S_PICK: begin
					if ((idx_q != loaded_q) && (run_st_q[ent] == ST_READY)) begin
						if (cfg.preemptive_mode) begin
							if (rank_q[ent] > run_rank_q) begin
								if (task_busy_q) begin
									run_st_q[run_idx_q] <= ST_READY;
								end
								run_st_q[ent] <= ST_EXEC;
							end
						end else begin
							run_st_q[ent] <= ST_EXEC;
						end
					end
				end
				S_RUN: begin
					if (task_busy_q && unit_hit) begin
						run_st_q[unit_addr] <= ST_SUSP;
					end
				end
				S_ADV: begin
					if ((idx_q != loaded_q) && unit_hit) begin
						run_st_q[ent] <= ST_READY;
					end
				end
				default: ;
			endcase
		end
	end

	// Counters per task, cleared at reset and on load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				progress_q[i] <= 16'd0;
				work_q[i]     <= 16'd0;
			end
		end else if (take && command && (loaded_q < MAX_CNT)) begin
			progress_q[loaded_q[IW-1:0]] <= 16'd0;
			work_q[loaded_q[IW-1:0]]     <= 16'd0;
		end else if ((state_q == S_RUN) && task_busy_q) begin
			work_q[unit_addr] <= unit_hit ? 16'd0 : unit_inc;
		end else if ((state_q == S_ADV) && (idx_q != loaded_q)) begin
			progress_q[ent] <= unit_hit ? 16'd0 : unit_inc;
			if (unit_hit && (run_st_q[ent] != ST_SUSP)) begin
				work_q[ent] <= 16'd0;
			end
		end
	end

	// Sequencer and scheduler control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			idx_q       <= '0;
			task_busy_q <= 1'b0;
			run_idx_q   <= '0;
			run_rank_q  <= 8'd0;
			time_q      <= 32'd0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						idx_q <= '0;
						if (command) begin
							if (loaded_q < MAX_CNT) begin
								loaded_q <= loaded_q + CW'(1);
							end
							done_q <= 1'b1;
						end else if (task_busy_q && !cfg.preemptive_mode) begin
							state_q <= S_RUN;
						end else begin
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					if (idx_q == loaded_q) begin
						state_q <= S_RUN;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (run_st_q[ent] == ST_READY) begin
							if (cfg.preemptive_mode) begin
								if (rank_q[ent] > run_rank_q) begin
									run_rank_q  <= rank_q[ent];
									run_idx_q   <= ent;
									task_busy_q <= 1'b1;
								end
							end else begin
								run_idx_q   <= ent;
								task_busy_q <= 1'b1;
								state_q     <= S_RUN;
							end
						end
					end
				end
				S_RUN: begin
					idx_q   <= '0;
					state_q <= S_ADV;
					if (task_busy_q) begin
						if (unit_hit) begin
							task_busy_q <= 1'b0;
							run_rank_q  <= 8'd0;
						end
					end else begin
						run_rank_q <= 8'd0;
					end
				end
				S_ADV: begin
					if (idx_q == loaded_q) begin
						time_q  <= time_q + {22'd0, cfg.tick_length_ms};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					ran_q        <= 4'd0;
					idle_q       <= 1'b0;
					miss_q       <= '0;
					slot_start_q <= time_q;
					accepted_q   <= command & (loaded_q < MAX_CNT);
				end
			end
			S_RUN: begin
				ran_q  <= task_busy_q ? 4'(run_idx_q) : 4'd0;
				idle_q <= ~task_busy_q;
			end
			S_ADV: begin
				if ((idx_q != loaded_q) && unit_hit && (run_st_q[ent] != ST_SUSP)) begin
					miss_q[ent] <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done               = done_q;
	assign ran_task           = ran_q;
	assign idle_slot          = idle_q;
	assign deadline_miss_mask = 16'(miss_q);
	assign slot_start_ms      = slot_start_q;
	assign load_accepted      = accepted_q;

	// A result is only shown once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while the sequencer is still working");

	// Every accepted command either starts the sequencer or finishes at once.
	assert property (@(posedge clk) disable iff (!arst_n) take |=> (busy || done))
		else $error("accepted command produced neither work nor a result");

	// An idle slot never reports a task index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle_slot) |-> (ran_task == 4'd0))
		else $error("idle slot reports a task index");

	// A stored load reports no scheduling activity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && load_accepted) |-> (!idle_slot && (deadline_miss_mask == 16'd0)))
		else $error("load result carries scheduling activity");

endmodule

// ===== test/periodic_task_tick_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top_tb;
	import ptts_pkg::*;

	localparam int TASK_SLOTS = 8;
	localparam int QUIET_LIMIT = 2000;
	// Cycles to let pass before a register write, longer than one full tick.
	localparam int SETTLE_CYCLES = 25;
	localparam int REPORT_LIMIT = 10;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [1:0] {
		TASK_READY     = 2'd0,
		TASK_RUNNING   = 2'd1,
		TASK_SUSPENDED = 2'd2
	} task_state_t;

	typedef struct packed {
		logic [3:0]  ran;
		logic        idle;
		logic [15:0] miss;
		logic [31:0] start_ms;
		logic        loaded;
	} slot_report_t;

	// Tracks the task table and predicts the report of every accepted command.
	class tick_schedule;
		bit [15:0]    period_of[TASK_SLOTS];
		bit [15:0]    budget_of[TASK_SLOTS];
		bit [7:0]     rank_of[TASK_SLOTS];
		task_state_t  state_of[TASK_SLOTS];
		bit [15:0]    progress[TASK_SLOTS];
		bit [15:0]    work[TASK_SLOTS];
		int           loaded;
		bit           busy;
		bit [3:0]     run_idx;
		bit [7:0]     run_rank;
		bit [31:0]    clock_ms;
		cfg_t         cfg;
		slot_report_t expected_slots[$];
		int           mismatches;

		function new();
			foreach (state_of[i]) begin
				period_of[i] = '0;
				budget_of[i] = '0;
				rank_of[i] = '0;
				state_of[i] = TASK_READY;
				progress[i] = '0;
				work[i] = '0;
			end
			loaded = 0;
			busy = 1'b0;
			run_idx = '0;
			run_rank = '0;
			clock_ms = '0;
			cfg.preemptive_mode = PREEMPT_RST;
			cfg.tick_length_ms = TICK_LEN_RST;
			mismatches = 0;
		endfunction

		function void set_config(logic idx, logic [31:0] value);
			if (idx == REG_PREEMPT) begin
				cfg.preemptive_mode = value[0];
			end else begin
				cfg.tick_length_ms = value[9:0];
			end
		endfunction

		function int pending();
			return expected_slots.size();
		endfunction

		function void record_command(logic cmd, logic [15:0] per, logic [15:0] bud,
				logic [7:0] rank);
			slot_report_t r;
			r = '0;
			r.start_ms = clock_ms;
			if (cmd == CMD_LOAD) begin
				// A full table drops the load; its report shows it as not accepted.
				if (loaded < TASK_SLOTS) begin
					period_of[loaded] = per;
					budget_of[loaded] = bud;
					rank_of[loaded] = rank;
					state_of[loaded] = TASK_READY;
					progress[loaded] = '0;
					work[loaded] = '0;
					loaded++;
					r.loaded = 1'b1;
				end
			end else begin
				// Pick pass, skipped while a task runs without preemption.
				if (!(busy && !cfg.preemptive_mode)) begin
					for (int i = 0; i < loaded; i++) begin
						if (state_of[i] != TASK_READY)
							continue;
						if (cfg.preemptive_mode) begin
							if (rank_of[i] > run_rank) begin
								if (busy)
									state_of[run_idx] = TASK_READY;
								state_of[i] = TASK_RUNNING;
								run_rank = rank_of[i];
								run_idx = 4'(i);
								busy = 1'b1;
							end
						end else begin
							state_of[i] = TASK_RUNNING;
							run_idx = 4'(i);
							busy = 1'b1;
							break;
						end
					end
				end
				// Charge the running task; it suspends once its budget is used up.
				if (busy) begin
					work[run_idx]++;
					if (work[run_idx] == budget_of[run_idx]) begin
						work[run_idx] = '0;
						state_of[run_idx] = TASK_SUSPENDED;
						busy = 1'b0;
						run_rank = '0;
					end
					r.ran = run_idx;
				end else begin
					run_rank = '0;
					r.idle = 1'b1;
				end
				// Period pass: a period that ends before the task suspended is a miss.
				for (int i = 0; i < loaded; i++) begin
					progress[i]++;
					if (progress[i] == period_of[i]) begin
						if (state_of[i] != TASK_SUSPENDED) begin
							r.miss[i] = 1'b1;
							work[i] = '0;
						end
						state_of[i] = TASK_READY;
						progress[i] = '0;
					end
				end
				clock_ms = clock_ms + 32'(cfg.tick_length_ms);
			end
			expected_slots.push_back(r);
		endfunction

		function void check_slot(slot_report_t got);
			slot_report_t want;
			if (expected_slots.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: report with no command outstanding: ran=%0d idle=%0b",
						$time, got.ran, got.idle);
				return;
			end
			want = expected_slots.pop_front();
			if (got.ran !== want.ran || got.idle !== want.idle || got.miss !== want.miss
					|| got.start_ms !== want.start_ms || got.loaded !== want.loaded) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: expected ran=%0d idle=%0b miss=%04h start=%0d loaded=%0b",
						$time, want.ran, want.idle, want.miss, want.start_ms, want.loaded);
					$display("%0t: actual   ran=%0d idle=%0b miss=%04h start=%0d loaded=%0b",
						$time, got.ran, got.idle, got.miss, got.start_ms, got.loaded);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        command = CMD_TICK;
	logic [15:0] task_period = '0;
	logic [15:0] task_budget = '0;
	logic [7:0]  task_rank = '0;
	logic        done;
	logic [3:0]  ran_task;
	logic        idle_slot;
	logic [15:0] deadline_miss_mask;
	logic [31:0] slot_start_ms;
	logic        load_accepted;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	tick_schedule sched = new();
	int quiet_cycles = 0;

	periodic_task_tick_scheduler_top #(
		.MAX_TASKS(TASK_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.task_period(task_period),
		.task_budget(task_budget),
		.task_rank(task_rank),
		.done(done),
		.ran_task(ran_task),
		.idle_slot(idle_slot),
		.deadline_miss_mask(deadline_miss_mask),
		.slot_start_ms(slot_start_ms),
		.load_accepted(load_accepted),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each report, then note each command transfer at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sched.check_slot({ran_task, idle_slot, deadline_miss_mask, slot_start_ms,
					load_accepted});
			if (start && !busy)
				sched.record_command(command, task_period, task_budget, task_rank);
		end
	end

	// Watchdog on cycles in which neither a command nor a report is transferred.
	always @(posedge clk) begin
		if (done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Present one command and hold it until it is transferred; start stays high.
	task automatic issue(logic cmd, logic [15:0] per, logic [15:0] bud, logic [7:0] rank);
		start <= 1'b1;
		command <= cmd;
		task_period <= per;
		task_budget <= bud;
		task_rank <= rank;
		do @(posedge clk); while (busy);
	endtask

	task automatic rest(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Wait for a clock edge first so that the last transfer has been noted by the monitor.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sched.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sched.set_config(idx, value);
	endtask

	// Rewrite both registers once the block is idle; upper data bits are noise.
	task automatic reconfigure(logic preempt, logic [9:0] tick_ms);
		logic [31:0] value;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		value = $urandom;
		value[0] = preempt;
		write_reg(REG_PREEMPT, value);
		value = $urandom;
		value[9:0] = tick_ms;
		write_reg(REG_TICK_LEN, value);
	endtask

	// Random commands in bursts; the table is full by now, so loads are ignored.
	task automatic run_phase(int count, bit gaps);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				issue(($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_TICK, 16'($urandom),
					16'($urandom), 8'($urandom));
				sent++;
				if (sent == count / 2)
					drain();
			end
			if (gaps && $urandom_range(0, 9) > 2)
				rest($urandom_range(1, 25));
		end
	endtask

	initial begin
		logic [15:0] per;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, rank zero under preemption, a top rank takeover,
		// a zero period, a task that keeps missing, then a full table.
		issue(CMD_TICK, 16'd0, 16'd0, 8'd0);
		issue(CMD_LOAD, 16'd4, 16'd2, 8'd0);
		issue(CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
		issue(CMD_TICK, 16'd0, 16'd0, 8'd0);
		issue(CMD_LOAD, 16'd6, 16'd3, 8'd10);
		repeat (3) issue(CMD_TICK, 16'd0, 16'd0, 8'd0);
		issue(CMD_LOAD, 16'hFFFF, 16'd1, 8'd255);
		issue(CMD_LOAD, 16'd0, 16'd2, 8'd128);
		repeat (2) issue(CMD_TICK, 16'd0, 16'd0, 8'd0);
		issue(CMD_LOAD, 16'd5, 16'd4, 8'd1);
		repeat (3) begin
			per = 16'($urandom_range(4, 16));
			issue(CMD_LOAD, per, 16'($urandom_range(1, per / 2)), 8'($urandom_range(1, 254)));
		end
		issue(CMD_LOAD, 16'd0, 16'd0, 8'd255);
		issue(CMD_LOAD, 16'hFFFF, 16'hFFFF, 8'd0);
		repeat (3) issue(CMD_TICK, 16'd0, 16'd0, 8'd0);

		// Random phases over the register settings, extremes first.
		reconfigure(1'b0, 10'd1000);
		run_phase(96, 1'b1);
		reconfigure(1'b1, 10'd1023);
		run_phase(96, 1'b1);
		reconfigure(1'b0, 10'd0);
		run_phase(96, 1'b0);
		reconfigure(1'b1, 10'($urandom_range(1, 1000)));
		run_phase(96, 1'b1);
		reconfigure(1'($urandom), 10'($urandom_range(0, 1023)));
		run_phase(96, 1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sched.mismatches == 0 && sched.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
